/* src/tpm_pkg.sv */
// shared types, constants and state encodings of the tach period rpm meter
package tpm_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 16;

   localparam logic [31:0] MIN_PERIOD_RESET = 32'd1000;
   localparam logic [31:0] THRESHOLD_RESET  = 32'd500000;
   localparam logic [31:0] PERIOD_MASK      = 32'hFFFF_FFFE;

   localparam longint unsigned TENTHS_NUM = 64'd600000000;

   localparam int RPM_W       = 20;
   localparam int QUO_W       = RPM_W + 1;
   localparam int STEP_W      = $clog2(QUO_W);
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_EDGE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic CSR_MIN_PERIOD = 1'b0;
   localparam logic CSR_THRESHOLD  = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [31:0] timestamp_us;
   } req_type;

   typedef struct packed {
      logic [RPM_W-1:0] rpm_tenths;
      logic [31:0]      jitter_us;
      logic [31:0]      period_us;
      logic             averaged;
   } rsp_type;

   typedef struct packed {
      logic [31:0] min_period_us;
      logic [31:0] single_period_threshold_us;
   } cfg_type;

   typedef struct packed {
      logic        timeout;
      logic        averaged;
      logic [31:0] jitter_us;
      logic [31:0] period_us;
   } job_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_UPDATE,
      FRONT_ISSUE
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

endpackage

/* src/tpm_front.sv */
// front end: event intake, bounce filter, period ring and running sum
module tpm_front #(
   parameter int WINDOW_DEPTH = tpm_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tpm_pkg::cfg_type                     cfg,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tpm_pkg::req_type                     req_data,
   output logic                                 job_valid,
   input  logic                                 job_ready,
   output tpm_pkg::job_type                     job_head,
   output logic [32+$clog2(WINDOW_DEPTH+1):0]   job_den
);
   import tpm_pkg::*;

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int MUL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int WP_W  = 32 + MUL_W;
   localparam int SUM_W = 32 + PTR_W;
   localparam int DEN_W = 33 + MUL_W;
   localparam logic [MUL_W-1:0] DEPTH_MUL = MUL_W'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);

   front_state_type state_ff, state_in;

   logic [31:0]             last_edge_ff;
   logic [31:0]             prev_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [PTR_W-1:0]        ptr_ff;
   logic [WINDOW_DEPTH-1:0] valid_ff;
   logic [31:0]             ring_mem [WINDOW_DEPTH];
   logic [31:0]             rd_data_ff;

   logic [31:0]   ts_ff;
   logic [31:0]   period_ff;
   logic [31:0]   jitter_ff;
   logic [WP_W-1:0] wp_ff;
   logic          avg_ff;
   logic          timeout_ff;

   logic             accept;
   logic             ring_we;
   logic [31:0]      raw;
   logic [31:0]      raw_even;
   logic [31:0]      jit;
   logic             edge_ok;
   logic [31:0]      old_entry;
   logic [SUM_W-1:0] sum_next;

   assign accept    = req_valid && req_ready;
   assign raw       = req_data.timestamp_us - last_edge_ff;
   assign raw_even  = raw & PERIOD_MASK;
   assign jit       = (raw >= prev_ff) ? (raw - prev_ff) : (prev_ff - raw);
   assign edge_ok   = (raw >= cfg.min_period_us);
   assign old_entry = valid_ff[ptr_ff] ? rd_data_ff : 32'd0;
   assign sum_next  = sum_ff - SUM_W'(old_entry) + SUM_W'(period_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_TIMEOUT) begin
                  state_in = FRONT_ISSUE;
               end else if (edge_ok) begin
                  state_in = FRONT_UPDATE;
               end
            end
         end
         FRONT_UPDATE: state_in = FRONT_ISSUE;
         FRONT_ISSUE: begin
            if (job_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      job_valid = 1'b0;
      ring_we   = 1'b0;
      unique case (state_ff)
         FRONT_IDLE:   req_ready = 1'b1;
         FRONT_UPDATE: ring_we   = 1'b1;
         FRONT_ISSUE:  job_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FRONT_IDLE;
         last_edge_ff <= '0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && req_data.opcode == OP_TIMEOUT) begin
            valid_ff <= '0;
            sum_ff   <= '0;
            prev_ff  <= '0;
         end
         if (ring_we) begin
            sum_ff           <= sum_next;
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
            prev_ff          <= period_ff;
            last_edge_ff     <= ts_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         timeout_ff <= req_data.opcode;
         ts_ff      <= req_data.timestamp_us;
         period_ff  <= raw_even;
         jitter_ff  <= jit;
         wp_ff      <= WP_W'(raw_even) * WP_W'(DEPTH_MUL);
      end
      if (ring_we) begin
         avg_ff <= !(period_ff > cfg.single_period_threshold_us);
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ptr_ff] <= period_ff;
      end
      rd_data_ff <= ring_mem[ptr_ff];
   end

   always_comb begin
      job_head.timeout   = timeout_ff;
      job_head.averaged  = !timeout_ff && avg_ff;
      job_head.jitter_us = timeout_ff ? 32'd0 : jitter_ff;
      job_head.period_us = timeout_ff ? 32'd0 : period_ff;
      if (timeout_ff) begin
         job_den = '0;
      end else if (avg_ff) begin
         job_den = DEN_W'(wp_ff) + DEN_W'(sum_ff);
      end else begin
         job_den = DEN_W'(period_ff);
      end
   end

endmodule

/* src/tpm_queue.sv */
// short fifo between the front end and the divider back end
module tpm_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   import tpm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/tpm_back.sv */
// back end: serial rounding divider and result register
module tpm_back #(
   parameter int WINDOW_DEPTH = tpm_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_valid,
   output logic                                 job_ready,
   input  tpm_pkg::job_type                     job_head,
   input  logic [32+$clog2(WINDOW_DEPTH+1):0]   job_den,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tpm_pkg::rsp_type                     rsp_data
);
   import tpm_pkg::*;

   localparam int MUL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int DEN_W = 33 + MUL_W;
   localparam int NUM_W = 31 + MUL_W;
   localparam int RW    = DEN_W + QUO_W;
   localparam logic [NUM_W-1:0] NUM_DIRECT = NUM_W'(TENTHS_NUM);
   localparam logic [NUM_W-1:0] NUM_AVG    =
      NUM_W'(TENTHS_NUM * 64'd2 * longint'(WINDOW_DEPTH));
   localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(QUO_W - 1);

   back_state_type state_ff, state_in;

   job_type           head_ff;
   logic [RW-1:0]     rem_ff;
   logic [RW-1:0]     div_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic             load_job;
   logic             load_out;
   logic             dividing;
   logic             ge;
   logic [NUM_W-1:0] num;
   logic [RPM_W-1:0] rpm;

   assign num = job_head.averaged ? NUM_AVG : NUM_DIRECT;
   assign ge  = (rem_ff >= div_ff);
   assign rpm = head_ff.timeout ? '0 : (quo_ff[QUO_W-1] ? '1 : quo_ff[RPM_W-1:0]);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (job_valid) begin
               state_in = job_head.timeout ? BACK_DONE : BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      dividing  = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BACK_IDLE:   job_ready = 1'b1;
         BACK_DIVIDE: dividing  = 1'b1;
         BACK_DONE:   load_out  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign load_job = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         head_ff <= job_head;
         rem_ff  <= RW'(num) + RW'(job_den >> 1);
         div_ff  <= RW'(job_den) << (QUO_W - 1);
         quo_ff  <= '0;
         step_ff <= STEP_FIRST;
      end else if (dividing) begin
         rem_ff  <= ge ? (rem_ff - div_ff) : rem_ff;
         div_ff  <= div_ff >> 1;
         quo_ff  <= {quo_ff[QUO_W-2:0], ge};
         step_ff <= step_ff - 1'b1;
      end
      if (load_out) begin
         rsp_data_ff.rpm_tenths <= rpm;
         rsp_data_ff.jitter_us  <= head_ff.jitter_us;
         rsp_data_ff.period_us  <= head_ff.period_us;
         rsp_data_ff.averaged   <= head_ff.averaged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/tach_period_rpm_meter_core.sv */
// top level of the tach period rpm meter: config registers, front end, queue, divider
//
//   channel  dir  handshake              payload
//   req_     in   req_valid/req_ready    req_data   (opcode, timestamp_us)
//   rsp_     out  rsp_valid/rsp_ready    rsp_data   (rpm_tenths, jitter_us, period_us, averaged)
//   csr_     in   csr_we                 csr_index, csr_wdata
//
// front end: edge via update and issue, timeout via issue only, dropped edge makes no job
// back end takes one job at a time through the 21-step serial divider
// a timeout result skips the divider in the back end
// a 2-entry queue parts front and back; rsp stalls hold the output register
// ring entries carry valid bits cleared by reset and timeout, no clearing pass
module tach_period_rpm_meter_core #(
   parameter int WINDOW_DEPTH = tpm_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);
   import tpm_pkg::*;

   localparam int DEN_W = 33 + $clog2(WINDOW_DEPTH + 1);
   localparam int JOB_W = $bits(job_type) + DEN_W;

   cfg_type cfg_ff;

   logic             push_valid;
   logic             push_ready;
   job_type          push_head;
   logic [DEN_W-1:0] push_den;
   logic             pop_valid;
   logic             pop_ready;
   logic [JOB_W-1:0] pop_data;
   job_type          pop_head;
   logic [DEN_W-1:0] pop_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_period_us              <= MIN_PERIOD_RESET;
         cfg_ff.single_period_threshold_us <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_PERIOD: cfg_ff.min_period_us              <= csr_wdata;
            CSR_THRESHOLD:  cfg_ff.single_period_threshold_us <= csr_wdata;
            default: ;
         endcase
      end
   end

   tpm_front #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_head  (push_head),
      .job_den   (push_den)
   );

   tpm_queue #(
      .DATA_W(JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_head, push_den}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_head = pop_data[JOB_W-1:DEN_W];
   assign pop_den  = pop_data[DEN_W-1:0];

   tpm_back #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_head  (pop_head),
      .job_den   (pop_den),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/tach_period_rpm_meter_core_test.sv */
// self-checking testbench of the tach period rpm meter core with a speed predictor
module tach_period_rpm_meter_core_test;
   import tpm_pkg::*;

   localparam int WINDOW         = WINDOW_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   class rpm_scoreboard;
      logic [31:0]     min_period;
      logic [31:0]     threshold;
      logic [31:0]     last_edge;
      logic [31:0]     ring [WINDOW];
      longint unsigned ring_sum;
      logic [3:0]      slot;
      rsp_type         pending_readings [$];
      int              errors;

      function new();
         min_period = MIN_PERIOD_RESET;
         threshold  = THRESHOLD_RESET;
         last_edge  = '0;
         foreach (ring[i]) ring[i] = '0;
         ring_sum = 0;
         slot     = '0;
         errors   = 0;
      endfunction

      function void write_reg(logic index, logic [31:0] value);
         if (index == CSR_MIN_PERIOD) min_period = value;
         else threshold = value;
      endfunction

      function logic [RPM_W-1:0] speed_div(longint unsigned num, longint unsigned den);
         longint unsigned q;
         if (den == 0) return '1;
         q = (num + den / 2) / den;
         if (q > 64'hF_FFFF) return '1;
         return q[RPM_W-1:0];
      endfunction

      // predicts the reading, if any, of one accepted item
      function void take_event(req_type item);
         logic [31:0] raw;
         logic [31:0] prev;
         logic [31:0] p;
         logic [3:0]  prev_slot;
         rsp_type     r;
         if (item.opcode == OP_TIMEOUT) begin
            foreach (ring[i]) ring[i] = '0;
            ring_sum = 0;
            pending_readings.push_back('0);
            return;
         end
         raw = item.timestamp_us - last_edge;
         if (raw < min_period) return;
         prev_slot = slot - 4'd1;
         prev = ring[prev_slot];
         r.jitter_us = (raw >= prev) ? raw - prev : prev - raw;
         p = raw & PERIOD_MASK;
         ring_sum = ring_sum - longint'(ring[slot]) + longint'(p);
         ring[slot] = p;
         slot = slot + 4'd1;
         r.period_us = p;
         if (p > threshold) begin
            r.rpm_tenths = speed_div(TENTHS_NUM, longint'(p));
            r.averaged   = 1'b0;
         end else begin
            r.rpm_tenths = speed_div(TENTHS_NUM * 2 * WINDOW,
                                     longint'(WINDOW) * longint'(p) + ring_sum);
            r.averaged   = 1'b1;
         end
         last_edge = item.timestamp_us;
         pending_readings.push_back(r);
      endfunction

      function void check_reading(rsp_type got);
         rsp_type want;
         if (pending_readings.size() == 0) begin
            $error("reading with none expected: rpm_tenths %0d period_us %0d",
                   got.rpm_tenths, got.period_us);
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         if (got.rpm_tenths !== want.rpm_tenths) begin
            $error("rpm_tenths: expected %0d, got %0d", want.rpm_tenths, got.rpm_tenths);
            errors++;
         end
         if (got.jitter_us !== want.jitter_us) begin
            $error("jitter_us: expected %0d, got %0d", want.jitter_us, got.jitter_us);
            errors++;
         end
         if (got.period_us !== want.period_us) begin
            $error("period_us: expected %0d, got %0d", want.period_us, got.period_us);
            errors++;
         end
         if (got.averaged !== want.averaged) begin
            $error("averaged: expected %0d, got %0d", want.averaged, got.averaged);
            errors++;
         end
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic        csr_index = CSR_MIN_PERIOD;
   logic [31:0] csr_wdata = '0;

   rpm_scoreboard sb = new();

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          hold_req       = 1'b0;
   int          hold_left      = 0;
   int          quiet_cycles   = 0;
   logic [31:0] cruise_period  = 32'd20000;

   tach_period_rpm_meter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_reading(rsp_data);
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tach_period_rpm_meter_core_test failed");
         $finish;
      end
   end

   task automatic send_event(input logic op, input logic [31:0] stamp);
      req_type item;
      item.opcode       = op;
      item.timestamp_us = stamp;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_event(item);
   endtask

   task automatic send_gap(input logic [31:0] gap);
      send_event(OP_EDGE, sb.last_edge + gap);
   endtask

   // wait for every reading, then let a dropped edge finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] min_period, input logic [31:0] threshold);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_PERIOD;
      csr_wdata <= min_period;
      @(posedge clock);
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(CSR_MIN_PERIOD, min_period);
      sb.write_reg(CSR_THRESHOLD, threshold);
   endtask

   task automatic random_events(input int count);
      int              pick;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned near_hi;
      logic [31:0]     gap;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         lo   = sb.min_period;
         hi   = lo + 600000;
         if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
         near_hi = (lo + 3000 > hi) ? hi : lo + 3000;
         if (n % 20 == 0) begin
            if ($urandom_range(1)) cruise_period = $urandom_range(hi, lo);
            else cruise_period = $urandom_range(near_hi, lo);
         end
         if (pick < 5) begin
            send_event(OP_TIMEOUT, $urandom);
         end else if (pick < 15) begin
            send_event(OP_EDGE, $urandom);
         end else begin
            if (pick < 25) begin
               gap = (sb.min_period == 0) ? 32'd0 : $urandom_range(sb.min_period - 1);
            end else if (pick < 35) begin
               case ($urandom_range(4))
                  0: gap = sb.min_period;
                  1: gap = sb.min_period - 1;
                  2: gap = sb.threshold;
                  3: gap = sb.threshold + 1;
                  default: gap = sb.threshold + 2;
               endcase
            end else if (pick < 50) begin
               gap = sb.threshold + 1 + $urandom_range(sb.threshold);
            end else begin
               gap = cruise_period + $urandom_range(cruise_period / 32);
            end
            send_gap(gap);
         end
      end
   endtask

   task automatic run_phase(input logic [31:0] min_period, input logic [31:0] threshold,
                            input int send_pct, input int recv_pct, input int count);
      settle();
      set_config(min_period, threshold);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      random_events(count);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, back to back
      send_event(OP_EDGE, 32'd0);
      send_event(OP_EDGE, 32'd1000);
      send_gap(32'd999);
      send_gap(32'd2001);
      send_gap(32'd500000);
      send_gap(32'd500001);
      send_gap(32'd500002);
      send_gap(32'hFFFF_FFFF);
      send_event(OP_TIMEOUT, 32'd0);
      send_gap(32'd20000);
      send_event(OP_TIMEOUT, 32'hFFFF_FFFF);
      send_event(OP_TIMEOUT, 32'd0);
      send_event(OP_EDGE, 32'hFFFF_FF00);
      send_event(OP_EDGE, 32'h0000_0300);
      send_event(OP_EDGE, 32'hFFFF_FFFF);
      for (int n = 0; n < 8; n++) send_gap(32'd1234 + n);

      // zero period with an empty window
      settle();
      set_config(32'd0, 32'hFFFF_FFFF);
      send_event(OP_TIMEOUT, 32'd0);
      send_gap(32'd0);
      send_gap(32'd1);
      send_gap(32'd0);
      random_events(150);

      run_phase(32'd50, 32'd0, 84, 0, 150);
      run_phase(MIN_PERIOD_RESET, THRESHOLD_RESET, 0, 84, 150);
      run_phase($urandom_range(5000), $urandom_range(2000000), 30, 30, 150);
      run_phase(32'hFFFF_FFFF, $urandom, 0, 0, 30);

      // receiver holds off while the sender keeps pushing
      settle();
      set_config(MIN_PERIOD_RESET, THRESHOLD_RESET);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req       = 1'b1;
      random_events(60);

      settle();
      if (sb.errors == 0) begin
         $display("tach_period_rpm_meter_core_test passed");
      end else begin
         $display("tach_period_rpm_meter_core_test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
src/tpm_pkg.sv
src/tpm_front.sv
src/tpm_queue.sv
src/tpm_back.sv
src/tach_period_rpm_meter_core.sv
bench/tach_period_rpm_meter_core_test.sv
